### rtl/msf_pkg.sv
// ---------------------------------------------------------------------------
// Multiloop segment features package
// Shared types, sizes and arithmetic helpers for the segment feature block.
// ---------------------------------------------------------------------------
package msf_pkg;

  // Largest legal position plus one.
  localparam int MAX_POSITIONS = 4096;

  localparam int POS_W = 12;
  localparam int CNT_W = 12;
  localparam int ASY_W = 13;

  typedef logic [POS_W-1:0] pos_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [ASY_W-1:0] asy_t;

  // One enclosed pair of a multiloop.
  typedef struct packed {
    pos_t loop_open;
    pos_t loop_close;
    pos_t pair_open;
    pos_t pair_close;
    logic first_pair;
    logic last_pair;
  } in_item_t;

  // Features reported for one pair.
  typedef struct packed {
    pos_t segment_length;
    pos_t final_segment;
    cnt_t unpaired_total;
    cnt_t branch_count;
    asy_t loop_asymmetry;
    logic totals_valid;
    logic bad_loop;
  } out_item_t;

  // True when a position lies outside the legal range.
  function automatic logic pos_oob(pos_t p);
    return 32'(p) >= MAX_POSITIONS;
  endfunction

  // Unpaired bases strictly between lo and hi, zero when hi is not above lo.
  function automatic pos_t gap(pos_t lo, pos_t hi);
    pos_t d;
    d = hi - lo - pos_t'(1);
    return (hi > lo) ? d : '0;
  endfunction

  function automatic pos_t abs_diff(pos_t a, pos_t b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  // Saturating add at count width.
  function automatic cnt_t sat_add_cnt(cnt_t a, cnt_t b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CNT_W] ? '1 : s[CNT_W-1:0];
  endfunction

  // Saturating add at asymmetry width.
  function automatic asy_t sat_add_asy(asy_t a, asy_t b);
    logic [ASY_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[ASY_W] ? '1 : s[ASY_W-1:0];
  endfunction

endpackage

### rtl/msf_if.sv
// ---------------------------------------------------------------------------
// Multiloop segment features channels
// Valid/ready channels for pair requests and feature results.
// ---------------------------------------------------------------------------

// Pair request channel.
interface msf_in_if;
  logic          valid;
  logic          ready;
  msf_pkg::pos_t loop_open;
  msf_pkg::pos_t loop_close;
  msf_pkg::pos_t pair_open;
  msf_pkg::pos_t pair_close;
  logic          first_pair;
  logic          last_pair;

  modport source (
    output valid, loop_open, loop_close, pair_open, pair_close, first_pair, last_pair,
    input  ready
  );
  modport sink (
    input  valid, loop_open, loop_close, pair_open, pair_close, first_pair, last_pair,
    output ready
  );
endinterface

// Feature result channel.
interface msf_out_if;
  logic          valid;
  logic          ready;
  msf_pkg::pos_t segment_length;
  msf_pkg::pos_t final_segment;
  msf_pkg::cnt_t unpaired_total;
  msf_pkg::cnt_t branch_count;
  msf_pkg::asy_t loop_asymmetry;
  logic          totals_valid;
  logic          bad_loop;

  modport source (
    output valid, segment_length, final_segment, unpaired_total, branch_count,
           loop_asymmetry, totals_valid, bad_loop,
    input  ready
  );
  modport sink (
    input  valid, segment_length, final_segment, unpaired_total, branch_count,
           loop_asymmetry, totals_valid, bad_loop,
    output ready
  );
endinterface

### rtl/multiloop_segment_features.sv
// ---------------------------------------------------------------------------
// Multiloop segment features
// Per-pair unpaired segment lengths and loop totals for one multiloop.
// ---------------------------------------------------------------------------
//  Channel   Direction  Contents
//  in_req    sink       closing pair, enclosed pair, first/last marks
//  out_res   source     segment length, loop totals, error flag
//
//  One pair per cycle sustained while the result channel is ready; a request passes
//  through the input register, then the feature logic, into the result register.
//  The loop accumulators update as a pair leaves the input register.
//  Synchronous active-low reset clears all control state and accumulators.
//  A stalled result holds; the input register keeps taking requests while
//  the result register can drain in the same cycle.
// ---------------------------------------------------------------------------
module multiloop_segment_features (
  input  logic      clk,
  input  logic      rst_n,
  msf_in_if.sink    in_req,
  msf_out_if.source out_res
);

  logic               s1_valid_r,  s1_valid_nxt;
  msf_pkg::in_item_t  s1_item_r;
  logic               out_valid_r, out_valid_nxt;
  msf_pkg::out_item_t out_item_r;
  msf_pkg::in_item_t  in_item;
  msf_pkg::out_item_t core_result;
  logic               in_accept;
  logic               out_free;
  logic               s1_fire;

  // Handshake control.
  assign out_free     = !out_valid_r || out_res.ready;
  assign s1_fire      = s1_valid_r && out_free;
  assign in_req.ready = !s1_valid_r || out_free;
  assign in_accept    = in_req.valid && in_req.ready;

  always_comb begin
    in_item.loop_open  = in_req.loop_open;
    in_item.loop_close = in_req.loop_close;
    in_item.pair_open  = in_req.pair_open;
    in_item.pair_close = in_req.pair_close;
    in_item.first_pair = in_req.first_pair;
    in_item.last_pair  = in_req.last_pair;
  end

  // Stage occupancy.
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (out_free) begin
      out_valid_nxt = s1_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_item_r <= in_item;
    end
    if (s1_fire) begin
      out_item_r <= core_result;
    end
  end

  // Feature logic and loop state.
  msf_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (s1_fire),
    .item   (s1_item_r),
    .result (core_result)
  );

  // Result drive.
  assign out_res.valid          = out_valid_r;
  assign out_res.segment_length = out_item_r.segment_length;
  assign out_res.final_segment  = out_item_r.final_segment;
  assign out_res.unpaired_total = out_item_r.unpaired_total;
  assign out_res.branch_count   = out_item_r.branch_count;
  assign out_res.loop_asymmetry = out_item_r.loop_asymmetry;
  assign out_res.totals_valid   = out_item_r.totals_valid;
  assign out_res.bad_loop       = out_item_r.bad_loop;

  // A pair leaving the input register always lands in the result register.
  a_fire_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire |=> out_valid_r)
    else $error("processed pair did not reach the result register");

  // Totals read as zero on results that are not the last of a loop.
  a_totals_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_item_r.totals_valid) |->
      (out_item_r.final_segment == '0) && (out_item_r.unpaired_total == '0) &&
      (out_item_r.branch_count == '0) && (out_item_r.loop_asymmetry == '0))
    else $error("loop totals present on a non-final result");

  // Fewer than two enclosed pairs must be flagged.
  a_short_loop_bad: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.totals_valid &&
     (out_item_r.branch_count < msf_pkg::cnt_t'(3))) |-> out_item_r.bad_loop)
    else $error("short loop not flagged");

  // Nothing enters the result register without a processed pair.
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid_r && !s1_fire) |=> !out_valid_r)
    else $error("result appeared without a processed pair");

endmodule

### rtl/msf_core.sv
// ---------------------------------------------------------------------------
// Multiloop segment features core
// Loop accumulators and the single-pass feature logic for one pair.
// ---------------------------------------------------------------------------
module msf_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  msf_pkg::in_item_t   item,
  output msf_pkg::out_item_t  result
);

  msf_pkg::pos_t prev_end_r,  prev_end_nxt;
  msf_pkg::pos_t first_seg_r, first_seg_nxt;
  msf_pkg::pos_t prev_seg_r,  prev_seg_nxt;
  msf_pkg::asy_t asy_sum_r,   asy_sum_nxt;
  msf_pkg::cnt_t unp_sum_r,   unp_sum_nxt;
  msf_pkg::cnt_t pair_cnt_r,  pair_cnt_nxt;
  logic          order_err_r, order_err_nxt;

  msf_pkg::pos_t base;
  msf_pkg::pos_t seg;
  msf_pkg::pos_t fin;
  msf_pkg::asy_t asy_base;
  msf_pkg::cnt_t unp_base;
  msf_pkg::cnt_t cnt_base;
  msf_pkg::asy_t asy_tmp;
  logic          err;

  // Per-pair feature logic; a first pair restarts the loop accumulators.
  always_comb begin
    base     = item.first_pair ? item.loop_open : prev_end_r;
    err      = item.first_pair ? msf_pkg::pos_oob(item.loop_open) : order_err_r;
    asy_base = item.first_pair ? '0 : asy_sum_r;
    unp_base = item.first_pair ? '0 : unp_sum_r;
    cnt_base = item.first_pair ? '0 : pair_cnt_r;

    if (msf_pkg::pos_oob(item.pair_open) || msf_pkg::pos_oob(item.pair_close) ||
        (item.pair_open <= base) || (item.pair_close <= item.pair_open)) begin
      err = 1'b1;
    end
    seg = msf_pkg::gap(base, item.pair_open);

    first_seg_nxt = item.first_pair ? seg : first_seg_r;
    asy_sum_nxt   = item.first_pair ? '0 :
                    msf_pkg::sat_add_asy(asy_base, {1'b0, msf_pkg::abs_diff(prev_seg_r, seg)});
    unp_sum_nxt   = msf_pkg::sat_add_cnt(unp_base, seg);
    pair_cnt_nxt  = msf_pkg::sat_add_cnt(cnt_base, msf_pkg::cnt_t'(1));
    prev_seg_nxt  = seg;
    prev_end_nxt  = item.pair_close;

    // Closing segment and loop totals on the last pair.
    fin     = '0;
    asy_tmp = '0;
    result  = '0;
    if (item.last_pair) begin
      if (msf_pkg::pos_oob(item.loop_close) || (item.loop_close <= item.pair_close)) begin
        err = 1'b1;
      end
      fin     = msf_pkg::gap(item.pair_close, item.loop_close);
      asy_tmp = msf_pkg::sat_add_asy(asy_sum_nxt, {1'b0, msf_pkg::abs_diff(seg, fin)});
      result.final_segment  = fin;
      result.loop_asymmetry = msf_pkg::sat_add_asy(asy_tmp,
                                {1'b0, msf_pkg::abs_diff(fin, first_seg_nxt)});
      result.unpaired_total = msf_pkg::sat_add_cnt(unp_sum_nxt, fin);
      result.branch_count   = msf_pkg::sat_add_cnt(pair_cnt_nxt, msf_pkg::cnt_t'(1));
    end
    order_err_nxt         = err;
    result.segment_length = seg;
    result.totals_valid   = item.last_pair;
    result.bad_loop       = err || (item.last_pair && (pair_cnt_nxt < msf_pkg::cnt_t'(2)));
  end

  // Loop state advances once per processed pair.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_end_r  <= '0;
      first_seg_r <= '0;
      prev_seg_r  <= '0;
      asy_sum_r   <= '0;
      unp_sum_r   <= '0;
      pair_cnt_r  <= '0;
      order_err_r <= 1'b0;
    end else if (fire) begin
      prev_end_r  <= prev_end_nxt;
      first_seg_r <= first_seg_nxt;
      prev_seg_r  <= prev_seg_nxt;
      asy_sum_r   <= asy_sum_nxt;
      unp_sum_r   <= unp_sum_nxt;
      pair_cnt_r  <= pair_cnt_nxt;
      order_err_r <= order_err_nxt;
    end
  end

endmodule

### tb/msf_tb_pkg.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Multiloop segment features scoreboard
// Tracks the loop state that the block should hold, works out the features
// for every accepted pair request and checks each result against them.
// ---------------------------------------------------------------------------
package msf_tb_pkg;

  class msf_feature_board;

    // Loop state as the block should hold it.
    msf_pkg::pos_t prev_end;
    msf_pkg::pos_t first_seg;
    msf_pkg::pos_t prev_seg;
    msf_pkg::asy_t asym_acc;
    msf_pkg::cnt_t unpaired_acc;
    msf_pkg::cnt_t pairs_seen;
    bit            order_bad;

    // Features still owed by the block, oldest first.
    msf_pkg::out_item_t pending_features[$];

    int errors;
    int results_checked;
    int loops_closed;
    int bad_flags;

    function new();
      prev_end     = '0;
      first_seg    = '0;
      prev_seg     = '0;
      asym_acc     = '0;
      unpaired_acc = '0;
      pairs_seen   = '0;
      order_bad    = 1'b0;
      errors          = 0;
      results_checked = 0;
      loops_closed    = 0;
      bad_flags       = 0;
    endfunction

    function int unsigned capped(int unsigned v, int unsigned cap);
      return (v > cap) ? cap : v;
    endfunction

    function int unsigned abs_gap(int unsigned a, int unsigned b);
      return (a > b) ? a - b : b - a;
    endfunction

    // Work out the features of one accepted pair and update the loop state.
    function void note_pair(msf_pkg::in_item_t r);
      msf_pkg::out_item_t f;
      int unsigned        lo_pos;
      int unsigned        lc_pos;
      int unsigned        po_pos;
      int unsigned        pc_pos;
      int unsigned        base_pos;
      int unsigned        seg;
      int unsigned        fin;
      int unsigned        asy_total;
      bit                 err;

      lo_pos = 32'(r.loop_open);
      lc_pos = 32'(r.loop_close);
      po_pos = 32'(r.pair_open);
      pc_pos = 32'(r.pair_close);
      fin = 0;
      f = '0;
      if (r.first_pair) begin
        base_pos     = lo_pos;
        pairs_seen   = '0;
        asym_acc     = '0;
        unpaired_acc = '0;
        order_bad    = (lo_pos >= msf_pkg::MAX_POSITIONS);
      end else begin
        base_pos = 32'(prev_end);
      end
      err = order_bad;
      if (po_pos >= msf_pkg::MAX_POSITIONS || pc_pos >= msf_pkg::MAX_POSITIONS)
        err = 1'b1;

      // Segment in front of this pair; a backward step counts as empty.
      if (po_pos <= base_pos) begin
        err = 1'b1;
        seg = 0;
      end else begin
        seg = po_pos - base_pos - 1;
      end
      if (pc_pos <= po_pos)
        err = 1'b1;

      if (r.first_pair)
        first_seg = msf_pkg::pos_t'(seg);
      else
        asym_acc = msf_pkg::asy_t'(capped(32'(asym_acc) + abs_gap(32'(prev_seg), seg), 8191));
      unpaired_acc = msf_pkg::cnt_t'(capped(32'(unpaired_acc) + seg, 4095));
      pairs_seen   = msf_pkg::cnt_t'(capped(32'(pairs_seen) + 1, 4095));
      prev_seg     = msf_pkg::pos_t'(seg);
      prev_end     = r.pair_close;

      // The last pair closes the loop and adds the closing segment.
      if (r.last_pair) begin
        if (lc_pos >= msf_pkg::MAX_POSITIONS)
          err = 1'b1;
        if (lc_pos <= pc_pos) begin
          err = 1'b1;
          fin = 0;
        end else begin
          fin = lc_pos - pc_pos - 1;
        end
        asy_total = capped(32'(asym_acc) + abs_gap(32'(prev_seg), fin), 8191);
        asy_total = capped(asy_total + abs_gap(fin, 32'(first_seg)), 8191);
        f.final_segment  = msf_pkg::pos_t'(fin);
        f.unpaired_total = msf_pkg::cnt_t'(capped(32'(unpaired_acc) + fin, 4095));
        f.branch_count   = msf_pkg::cnt_t'(capped(32'(pairs_seen) + 1, 4095));
        f.loop_asymmetry = msf_pkg::asy_t'(asy_total);
      end
      order_bad = err;

      f.segment_length = msf_pkg::pos_t'(seg);
      f.totals_valid   = r.last_pair;
      f.bad_loop       = err || (r.last_pair && (32'(pairs_seen) < 2));
      pending_features = {pending_features, f};
    endfunction

    function void compare_field(string name, int unsigned exp_v, int unsigned act_v);
      if (exp_v != act_v) begin
        $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
        errors++;
      end
    endfunction

    // Compare one accepted result with the oldest owed features.
    function void check_features(msf_pkg::out_item_t got);
      msf_pkg::out_item_t want;

      if (pending_features.size() == 0) begin
        $error("result accepted with no request outstanding");
        errors++;
        return;
      end
      want = pending_features.pop_front();
      results_checked++;
      if (want.totals_valid)
        loops_closed++;
      if (want.bad_loop)
        bad_flags++;
      compare_field("segment_length", 32'(want.segment_length), 32'(got.segment_length));
      compare_field("final_segment", 32'(want.final_segment), 32'(got.final_segment));
      compare_field("unpaired_total", 32'(want.unpaired_total), 32'(got.unpaired_total));
      compare_field("branch_count", 32'(want.branch_count), 32'(got.branch_count));
      compare_field("loop_asymmetry", 32'(want.loop_asymmetry), 32'(got.loop_asymmetry));
      compare_field("totals_valid", 32'(want.totals_valid), 32'(got.totals_valid));
      compare_field("bad_loop", 32'(want.bad_loop), 32'(got.bad_loop));
    endfunction

    function int outstanding();
      return pending_features.size();
    endfunction

  endclass

endpackage

### tb/tb_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Multiloop segment features testbench
// Drives directed and random pair requests with random idle gaps on both
// channels, including one long result stall, and checks every result.
// ---------------------------------------------------------------------------
module tb_top;

  // Ways in which a well-formed loop gets broken.
  typedef enum int {
    FLIP_FIRST,
    FLIP_LAST,
    SWAP_ENDS,
    WILD_OPEN,
    SHORT_CLOSE
  } fault_t;

  localparam int RANDOM_ITEMS = 1480;
  localparam int QUIET_ITEMS  = 200;
  localparam int CHAIN_ITEMS  = 200;
  localparam int HOLD_CYCLES  = 80;

  logic clk;
  logic rst_n;

  msf_in_if  in_req();
  msf_out_if out_res();

  multiloop_segment_features dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_res (out_res)
  );

  msf_tb_pkg::msf_feature_board board;

  int requests_sent;
  int hold_requests;
  bit quiet;

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Run limit.
  initial begin
    #2000000;
    $display("multiloop_segment_features verification failed");
    $finish;
  end

  function automatic msf_pkg::in_item_t pair_req(int unsigned lo, int unsigned lc,
                                                 int unsigned po, int unsigned pc,
                                                 bit f, bit l);
    msf_pkg::in_item_t r;
    r.loop_open  = msf_pkg::pos_t'(lo);
    r.loop_close = msf_pkg::pos_t'(lc);
    r.pair_open  = msf_pkg::pos_t'(po);
    r.pair_close = msf_pkg::pos_t'(pc);
    r.first_pair = f;
    r.last_pair  = l;
    return r;
  endfunction

  function automatic msf_pkg::in_item_t noise_req();
    return pair_req($urandom_range(0, 4095), $urandom_range(0, 4095),
                    $urandom_range(0, 4095), $urandom_range(0, 4095),
                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endfunction

  // Offer one request, with an occasional idle burst ahead of it.
  task automatic send_req(msf_pkg::in_item_t r);
    int gap_cycles;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap_cycles = $urandom_range(1, 3);
      repeat (gap_cycles) begin
        @(negedge clk);
        in_req.valid <= 1'b0;
      end
    end
    @(negedge clk);
    in_req.valid      <= 1'b1;
    in_req.loop_open  <= r.loop_open;
    in_req.loop_close <= r.loop_close;
    in_req.pair_open  <= r.pair_open;
    in_req.pair_close <= r.pair_close;
    in_req.first_pair <= r.first_pair;
    in_req.last_pair  <= r.last_pair;
    @(posedge clk);
    while (!in_req.ready) @(posedge clk);
    board.note_pair(r);
    requests_sent++;
  endtask

  // One loop of n ordered pairs, optionally broken at one pair.
  task automatic run_loop(int n, bit broken);
    int unsigned       lo;
    int unsigned       lc;
    int unsigned       room;
    int unsigned       step_cap;
    int unsigned       cur;
    int unsigned       po[$];
    int unsigned       pc[$];
    int                bad_at;
    fault_t            fault;
    msf_pkg::in_item_t r;
    int unsigned       tmp;

    lo   = $urandom_range(0, 4095 - (2 * n + 1));
    room = (4095 - lo) / (2 * n + 1);
    // Tight spacing gives many empty segments; wide spacing gives long ones.
    if ($urandom_range(0, 1) == 0) begin
      step_cap = $urandom_range(1, 3);
      if (step_cap > room)
        step_cap = room;
    end else begin
      step_cap = $urandom_range(1, room);
    end
    cur = lo;
    for (int i = 0; i < n; i++) begin
      cur = cur + $urandom_range(1, step_cap);
      po  = {po, cur};
      cur = cur + $urandom_range(1, step_cap);
      pc  = {pc, cur};
    end
    lc = cur + $urandom_range(1, step_cap);

    bad_at = broken ? $urandom_range(0, n - 1) : -1;
    fault  = fault_t'($urandom_range(0, 4));
    for (int i = 0; i < n; i++) begin
      r = pair_req(lo, lc, po[i], pc[i], i == 0, i == n - 1);
      if (i == bad_at) begin
        case (fault)
          FLIP_FIRST:  r.first_pair = ~r.first_pair;
          FLIP_LAST:   r.last_pair = ~r.last_pair;
          SWAP_ENDS: begin
            tmp = r.pair_open;
            r.pair_open  = r.pair_close;
            r.pair_close = msf_pkg::pos_t'(tmp);
          end
          WILD_OPEN:   r.pair_open = msf_pkg::pos_t'($urandom_range(0, 4095));
          SHORT_CLOSE: r.loop_close = msf_pkg::pos_t'($urandom_range(0, lc));
          default:     r.loop_open = msf_pkg::pos_t'($urandom_range(0, 4095));
        endcase
      end
      send_req(r);
    end
  endtask

  // Result side: random stall bursts, one long hold-off on request.
  initial begin
    int                 stall_left;
    int                 hold_left;
    int                 hold_served;
    msf_pkg::out_item_t got;

    stall_left    = 0;
    hold_left     = 0;
    hold_served   = 0;
    out_res.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left == 0 && hold_served < hold_requests) begin
        hold_served++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_res.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_res.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 2);
        out_res.ready <= 1'b0;
      end else begin
        out_res.ready <= 1'b1;
      end
      @(posedge clk);
      if (rst_n && out_res.valid && out_res.ready) begin
        got.segment_length = out_res.segment_length;
        got.final_segment  = out_res.final_segment;
        got.unpaired_total = out_res.unpaired_total;
        got.branch_count   = out_res.branch_count;
        got.loop_asymmetry = out_res.loop_asymmetry;
        got.totals_valid   = out_res.totals_valid;
        got.bad_loop       = out_res.bad_loop;
        board.check_features(got);
      end
    end
  end

  // Request side and run control.
  initial begin
    int                target;
    int                pick;
    int                n;
    msf_pkg::in_item_t r;

    board         = new();
    requests_sent = 0;
    hold_requests = 0;
    quiet         = 1'b0;

    rst_n             = 1'b0;
    in_req.valid      = 1'b0;
    in_req.loop_open  = '0;
    in_req.loop_close = '0;
    in_req.pair_open  = '0;
    in_req.pair_close = '0;
    in_req.first_pair = 1'b0;
    in_req.last_pair  = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Continuing without a first mark straight after reset.
    send_req(pair_req(0, 0, 5, 10, 1'b0, 1'b0));
    send_req(pair_req(0, 20, 12, 15, 1'b0, 1'b1));
    // First and last on the same pair.
    send_req(pair_req(3, 9, 4, 5, 1'b1, 1'b1));
    // Tightly packed loop with every segment empty.
    send_req(pair_req(0, 7, 1, 2, 1'b1, 1'b0));
    send_req(pair_req(0, 7, 3, 4, 1'b0, 1'b0));
    send_req(pair_req(0, 7, 5, 6, 1'b0, 1'b1));
    // Loop spanning the whole position range.
    send_req(pair_req(0, 4095, 2000, 2001, 1'b1, 1'b0));
    send_req(pair_req(0, 4095, 4093, 4094, 1'b0, 1'b1));
    // Opening base at the top of the range, then everything at the top.
    send_req(pair_req(4095, 0, 0, 0, 1'b1, 1'b0));
    send_req(pair_req(4095, 4095, 4095, 4095, 1'b0, 1'b1));
    // Pair opening at or below the previous end.
    send_req(pair_req(10, 100, 20, 30, 1'b1, 1'b0));
    send_req(pair_req(10, 100, 30, 40, 1'b0, 1'b0));
    send_req(pair_req(10, 100, 35, 50, 1'b0, 1'b1));
    // Pair closing at its own opening.
    send_req(pair_req(0, 50, 10, 10, 1'b1, 1'b0));
    send_req(pair_req(0, 50, 20, 30, 1'b0, 1'b1));
    // Closing base at the last pair's close, then continuing past the end.
    send_req(pair_req(0, 40, 10, 20, 1'b1, 1'b0));
    send_req(pair_req(0, 40, 25, 40, 1'b0, 1'b1));
    send_req(pair_req(0, 0, 45, 60, 1'b0, 1'b0));
    send_req(pair_req(0, 0, 0, 0, 1'b0, 1'b0));

    // One long noisy loop so that the sums saturate.
    send_req(pair_req($urandom_range(0, 4095), 0, $urandom_range(0, 4095),
                      $urandom_range(0, 4095), 1'b1, 1'b0));
    for (int i = 1; i < CHAIN_ITEMS; i++) begin
      r = noise_req();
      r.first_pair = 1'b0;
      r.last_pair  = (i == CHAIN_ITEMS - 1);
      send_req(r);
    end

    // Mostly well-formed loops, some broken, some plain noise.
    target = requests_sent + RANDOM_ITEMS;
    while (requests_sent < target) begin
      if (requests_sent >= target - QUIET_ITEMS)
        quiet = 1'b1;
      if (hold_requests == 0 && requests_sent >= target - RANDOM_ITEMS + 400)
        hold_requests = 1;
      pick = $urandom_range(0, 9);
      if (pick < 2) begin
        repeat ($urandom_range(1, 4)) send_req(noise_req());
      end else begin
        pick = $urandom_range(0, 19);
        if (pick < 14)
          n = $urandom_range(1, 6);
        else if (pick < 19)
          n = $urandom_range(7, 20);
        else
          n = $urandom_range(21, 60);
        run_loop(n, $urandom_range(0, 4) == 0);
      end
    end
    @(negedge clk);
    in_req.valid <= 1'b0;

    // Drain, then keep watching for anything stray before the summary.
    while (board.outstanding() > 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Checked %0d results over %0d requests: %0d loops closed, %0d flagged bad.",
             board.results_checked, requests_sent, board.loops_closed, board.bad_flags);
    $display("Covered directed corner loops, a saturating noisy loop and random loops.");
    if (board.errors == 0 && board.outstanding() == 0) begin
      $display("multiloop_segment_features verification clean");
    end else begin
      $display("multiloop_segment_features verification failed");
    end
    $finish;
  end

endmodule
